### sv/kcl_pkg.sv
// shared types, constants and key table of the keypad code lock
`default_nettype none

package kcl_pkg;

  // code geometry
  localparam int CODE_LENGTH = 4;
  localparam int USER_COUNT  = 3;
  localparam int UserN       = (USER_COUNT < 3) ? USER_COUNT : 3;
  localparam int CntW        = $clog2(CODE_LENGTH + 1);
  localparam int IdxW        = (CODE_LENGTH > 1) ? $clog2(CODE_LENGTH) : 1;
  localparam int PackW       = CODE_LENGTH * 8;
  localparam int CmpW        = (PackW > 32) ? PackW : 32;

  // field widths
  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 32;
  localparam int CharW    = 8;
  localparam int FailW    = 4;
  localparam int LockW    = 8;

  typedef enum logic [2:0] {
    ST_TAKEN   = 3'd0,
    ST_GRANTED = 3'd1,
    ST_WRONG   = 3'd2,
    ST_LOCKED  = 3'd3,
    ST_TICK    = 3'd4,
    ST_IGNORED = 3'd5
  } status_e;

  typedef enum logic {
    OP_KEY  = 1'b0,
    OP_TICK = 1'b1
  } opcode_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_CODE_USER_ZERO = 3'd0,
    CFG_CODE_USER_ONE  = 3'd1,
    CFG_CODE_USER_TWO  = 3'd2,
    CFG_ATTEMPT_LIMIT  = 3'd3,
    CFG_LOCKOUT_TICKS  = 3'd4
  } cfg_reg_e;

  localparam logic [1:0] NO_USER = 2'd3;

  // keypad position to ascii character
  function automatic logic [7:0] key_map(input logic [4:0] pos);
    logic [7:0] ch;
    case (pos)
      5'd0:    ch = 8'd0;
      5'd1:    ch = "1";
      5'd2:    ch = "2";
      5'd3:    ch = "3";
      5'd4:    ch = "A";
      5'd5:    ch = "4";
      5'd6:    ch = "5";
      5'd7:    ch = "6";
      5'd8:    ch = "B";
      5'd9:    ch = "7";
      5'd10:   ch = "8";
      5'd11:   ch = "9";
      5'd12:   ch = "C";
      5'd13:   ch = "*";
      5'd14:   ch = "0";
      5'd15:   ch = "#";
      5'd16:   ch = "D";
      default: ch = "V";
    endcase
    return ch;
  endfunction

endpackage

`default_nettype wire

### sv/keypad_code_lock_top.sv
// keypad code lock: key entry, code match, failure count and lockout timer
//
//  channel | signals                                   | direction
//  --------+-------------------------------------------+----------
//  in      | in_valid_i, in_stall_o, opcode_i, key_pos | into block
//  out     | out_valid_o, out_stall_i, six result fields | out of block
//  cfg     | cfg_valid_i, cfg_ready_o, index, data     | into block
//
// one item per cycle while the input is not stalled; each accepted item updates the lock state at once and
// its result appears in the output register on the next cycle.
// the input stalls only while a result sits unread and the sink stalls.
// reset clears the counters and loads the default user codes and limits.
// configuration is always ready and takes one write per cycle.
`default_nettype none

module keypad_code_lock_top (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  // input transactions
  input  wire logic                           in_valid_i,
  output logic                                in_stall_o,
  input  wire logic                           opcode_i,
  input  wire logic [4:0]                     key_position_i,
  // result transactions
  output logic                                out_valid_o,
  input  wire logic                           out_stall_i,
  output logic [2:0]                          status_o,
  output logic [1:0]                          user_index_o,
  output logic [2:0]                          keys_held_o,
  output logic [3:0]                          attempts_used_o,
  output logic [7:0]                          lock_remaining_o,
  output logic [7:0]                          key_char_o,
  // configuration writes
  input  wire logic                           cfg_valid_i,
  output logic                                cfg_ready_o,
  input  wire logic [kcl_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  wire logic [kcl_pkg::CfgDataW-1:0]   cfg_data_i
);

  import kcl_pkg::*;

  logic              in_acc;
  logic              out_acc;

  logic [31:0]       code_q [3];
  logic [FailW-1:0]  limit_q;
  logic [LockW-1:0]  ticks_q;

  logic [CharW-1:0]  chars_q [CODE_LENGTH];
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic [FailW-1:0]  fail_q, fail_d;
  logic [LockW-1:0]  lock_q, lock_d;

  logic              out_valid_q;
  status_e           status_q, status_d;
  logic [1:0]        user_q, user_d;
  logic [CharW-1:0]  char_q, char_d;

  logic              wr_en;
  logic [PackW-1:0]  packed_code;
  logic [1:0]        match_idx;
  logic [FailW-1:0]  fail_inc;
  logic [FailW-1:0]  lim;

  // handshakes
  assign cfg_ready_o = 1'b1;
  assign out_acc     = out_valid_q & ~out_stall_i;
  assign in_stall_o  = out_valid_q & out_stall_i;
  assign in_acc      = in_valid_i & ~in_stall_o;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      code_q[0] <= 32'd825373492;
      code_q[1] <= 32'd875770417;
      code_q[2] <= 32'd1094861636;
      limit_q   <= 4'd3;
      ticks_q   <= 8'd5;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CFG_CODE_USER_ZERO: code_q[0] <= cfg_data_i;
        CFG_CODE_USER_ONE:  code_q[1] <= cfg_data_i;
        CFG_CODE_USER_TWO:  code_q[2] <= cfg_data_i;
        CFG_ATTEMPT_LIMIT:  limit_q   <= cfg_data_i[FailW-1:0];
        CFG_LOCKOUT_TICKS:  ticks_q   <= cfg_data_i[LockW-1:0];
        default: ;
      endcase
    end
  end

  // code packed with the incoming key in the last slot, first key on top
  always_comb begin
    packed_code = '0;
    for (int i = 0; i < CODE_LENGTH; i++) begin
      packed_code[(CODE_LENGTH-1-i)*8 +: 8] =
        (i == CODE_LENGTH - 1) ? key_map(key_position_i) : chars_q[i];
    end
  end

  // first matching user wins
  always_comb begin
    match_idx = NO_USER;
    for (int u = UserN - 1; u >= 0; u--) begin
      if (CmpW'(packed_code) == CmpW'(code_q[u])) begin
        match_idx = 2'(u);
      end
    end
  end

  assign fail_inc = fail_q + 4'd1;
  assign lim      = (limit_q == '0) ? 4'd1 : limit_q;

  // next state and result
  always_comb begin
    status_d = ST_IGNORED;
    user_d   = NO_USER;
    char_d   = '0;
    cnt_d    = cnt_q;
    fail_d   = fail_q;
    lock_d   = lock_q;
    wr_en    = 1'b0;
    if (opcode_e'(opcode_i) == OP_TICK) begin
      if (lock_q != '0) begin
        lock_d   = lock_q - 8'd1;
        status_d = ST_TICK;
        if (lock_q == 8'd1) begin
          fail_d = '0;
        end
      end
    end else if (lock_q != '0) begin
      status_d = ST_LOCKED;
    end else if (key_position_i != '0) begin
      char_d   = key_map(key_position_i);
      wr_en    = 1'b1;
      status_d = ST_TAKEN;
      if (cnt_q == CntW'(CODE_LENGTH - 1)) begin
        cnt_d  = '0;
        user_d = match_idx;
        if (match_idx != NO_USER) begin
          status_d = ST_GRANTED;
          fail_d   = '0;
        end else begin
          status_d = ST_WRONG;
          fail_d   = fail_inc;
          if (fail_inc >= lim) begin
            lock_d = ticks_q;
            if (ticks_q == '0) begin
              fail_d = '0;
            end
          end
        end
      end else begin
        cnt_d = cnt_q + CntW'(1);
      end
    end
  end

  // lock state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      fail_q <= '0;
      lock_q <= '0;
    end else if (in_acc) begin
      cnt_q  <= cnt_d;
      fail_q <= fail_d;
      lock_q <= lock_d;
    end
  end

  // entered characters, no reset needed
  always_ff @(posedge clk_i) begin
    if (in_acc && wr_en) begin
      chars_q[cnt_q[IdxW-1:0]] <= char_d;
    end
  end

  // result valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_acc) begin
      out_valid_q <= 1'b1;
    end else if (out_acc) begin
      out_valid_q <= 1'b0;
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      status_q <= status_d;
      user_q   <= user_d;
      char_q   <= char_d;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign status_o         = status_q;
  assign user_index_o     = user_q;
  assign keys_held_o      = 3'(cnt_q);
  assign attempts_used_o  = fail_q;
  assign lock_remaining_o = lock_q;
  assign key_char_o       = char_q;

endmodule

`default_nettype wire

### sv/kcl_checker.sv
// port-level checks on the keypad code lock and their bind
`default_nettype none

module kcl_checker (
  input wire logic                         clk_i,
  input wire logic                         rst_ni,
  input wire logic                         out_valid_o,
  input wire logic                         out_stall_i,
  input wire logic [2:0]                   status_o,
  input wire logic [1:0]                   user_index_o,
  input wire logic [2:0]                   keys_held_o,
  input wire logic [3:0]                   attempts_used_o,
  input wire logic [7:0]                   lock_remaining_o,
  input wire logic [7:0]                   key_char_o
);

  import kcl_pkg::*;

  // a stalled result stays valid
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // a grant names a user and clears the entry and failures
  a_grant: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == ST_GRANTED |->
      user_index_o != NO_USER && keys_held_o == '0 && attempts_used_o == '0)
    else $error("grant with inconsistent state");

  // only a grant reports a user
  a_user: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != ST_GRANTED |-> user_index_o == NO_USER)
    else $error("user reported without grant");

  // a key refused by the lock leaves it locked and maps to no character
  a_locked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == ST_LOCKED |->
      lock_remaining_o != '0 && key_char_o == '0)
    else $error("locked status while open");

  // a wrong code always leaves the entry empty
  a_wrong: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == ST_WRONG |-> keys_held_o == '0 && key_char_o != '0)
    else $error("wrong code with keys still held");

endmodule

bind keypad_code_lock_top kcl_checker u_kcl_checker (.*);

`default_nettype wire
